@@ hw/rtl/r2dcf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r2dcf_pkg
// Shared types and constants of the RGB 2D convolution filter.
// ----------------------------------------------------------------------------
package r2dcf_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_PIXEL = 2'd1,
    CMD_DRAIN = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_KERNEL = 2'd2,
    REG_NONE   = 2'd3
  } cfg_reg_e;

  localparam int ROW_W      = 12;
  localparam int COL_W      = 10;
  localparam int WIDTH_W    = 11;
  localparam int HEIGHT_W   = 13;
  localparam int KSIZE_W    = 3;
  localparam int ROW_LIMIT  = 4096;
  localparam int PIX_W      = 24;
  localparam int COEF_W     = 16;
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PW    = 3;

  typedef struct packed {
    logic             last;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [7:0]       blue;
    logic [7:0]       green;
    logic [7:0]       red;
  } beat_t;

endpackage

@@ hw/rtl/rgb_2d_convolution_filter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_2d_convolution_filter
// Zero-padded odd KxK convolution of a raster RGB stream, per channel.
// ----------------------------------------------------------------------------
// Takes one request per clock and gives one filtered pixel per clock unless
// stalled. Each pixel or drain request moves one column through MAX_KERNEL-1
// line-buffer RAMs (read at accept, written back in the next cycle, with
// forwarding when the same column is hit in consecutive cycles) into a KxK
// window; results pass registered stages a, b, c and d into an eight-entry
// output queue, and input stalls when that queue and the results in flight
// fill it. The first filtered pixel appears with the pixel that completes
// its window, (K-1)/2 rows and (K-1)/2 columns later; drain requests push
// out the rest. When a frame ends before that pixel, input holds after its
// last pixel while zero columns advance the window, one per clock while the
// queue has space, until the first filtered pixel has left for the queue.
module rgb_2d_convolution_filter
  import r2dcf_pkg::*;
#(
  parameter int MAX_KERNEL         = 5,
  parameter int MAX_WIDTH          = 1024,
  parameter int COEF_FRACTION_BITS = 14
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [HEIGHT_W-1:0] cfg_data_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // coef_index[4:0], coef_value[20:5], in_red[28:21], in_green[36:29],
  // in_blue[44:37], zero fill
  input  logic [47:0]         s_axis_tdata,
  // cmd[1:0]
  input  logic [1:0]          s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // out_red[7:0], out_green[15:8], out_blue[23:16], out_row[35:24],
  // out_column[45:36], zero fill
  output logic [47:0]         m_axis_tdata,
  output logic                m_axis_tlast
);

  localparam int MK    = MAX_KERNEL;
  localparam int KODD  = (MK % 2 == 1) ? MK : MK - 1;
  localparam int KW    = $clog2(MK + 1);
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int DMAX  = ((MK - 1) / 2) * (MAX_WIDTH + 1);
  localparam int DW    = $clog2(DMAX + 1) + 1;
  localparam int NCOEF = MK * MK;
  localparam int CIW   = (NCOEF > 1) ? $clog2(NCOEF) : 1;
  localparam int PW    = 8 + COEF_W + 1;
  localparam int SW    = PW + $clog2(NCOEF) + 2;

  // configuration
  logic [WIDTH_W-1:0]  width_q;
  logic [HEIGHT_W-1:0] height_q;
  logic [KSIZE_W-1:0]  ksize_q;
  cfg_reg_e            cfg_reg;

  assign cfg_ready_o = 1'b1;
  assign cfg_reg     = cfg_reg_e'(cfg_index_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_W'(1024);
      height_q <= HEIGHT_W'(1024);
      ksize_q  <= KSIZE_W'(3);
    end else if (cfg_valid_i) begin
      case (cfg_reg)
        REG_WIDTH:  width_q  <= cfg_data_i[WIDTH_W-1:0];
        REG_HEIGHT: height_q <= cfg_data_i;
        REG_KERNEL: ksize_q  <= cfg_data_i[KSIZE_W-1:0];
        default: ;
      endcase
    end
  end

  logic [CW:0]       w_eff;
  logic [HEIGHT_W-1:0] h_eff;
  logic [KW-1:0]     k_eff;
  logic [KW-1:0]     step;
  logic [DW-1:0]     dlag;

  always_comb begin
    int wv, hv, kv;
    wv = int'(width_q);
    hv = int'(height_q);
    kv = int'(ksize_q);
    if (wv < 1) wv = 1;
    if (wv > MAX_WIDTH) wv = MAX_WIDTH;
    if (hv < 1) hv = 1;
    if (hv > ROW_LIMIT) hv = ROW_LIMIT;
    if (kv == 0) kv = 1;
    if (kv % 2 == 0) kv = kv - 1;
    if (kv > KODD) kv = KODD;
    w_eff = (CW+1)'(wv);
    h_eff = HEIGHT_W'(hv);
    k_eff = KW'(kv);
    step  = KW'((kv - 1) / 2);
    dlag  = DW'(((kv - 1) / 2) * wv + (kv - 1) / 2);
  end

  // request decode
  cmd_e              cmd;
  logic [4:0]        in_cidx;
  logic [COEF_W-1:0] in_cval;
  logic [PIX_W-1:0]  in_pix;
  logic              in_acc, is_pix, is_drn, is_load, feed, emit;
  logic              last_in, out_last;

  assign cmd     = cmd_e'(s_axis_tuser);
  assign in_cidx = s_axis_tdata[4:0];
  assign in_cval = s_axis_tdata[20:5];
  assign in_pix  = {s_axis_tdata[28:21], s_axis_tdata[36:29], s_axis_tdata[44:37]};
  assign in_acc  = s_axis_tvalid && s_axis_tready;

  logic [CW-1:0]    vc_q, vc_d, pc_q, pc_d;
  logic [ROW_W-1:0] vr_q, vr_d, pr_q, pr_d;
  logic [DW-1:0]    fcnt_q, fcnt_d;
  logic             done_q, done_d;
  logic             pend_q, pend_d;
  logic             space, int_feed, int_emit;

  assign is_pix   = in_acc && (cmd == CMD_PIXEL) && !done_q;
  assign is_drn   = in_acc && (cmd == CMD_DRAIN) && done_q;
  assign is_load  = in_acc && (cmd == CMD_LOAD) && (int'(in_cidx) < NCOEF);
  assign int_feed = pend_q && space;
  assign int_emit = int_feed && (fcnt_q >= dlag);
  assign feed     = is_pix || is_drn || int_feed;
  assign last_in = ({1'b0, vr_q} == (h_eff - HEIGHT_W'(1)))
                && ({1'b0, vc_q} == (w_eff - (CW+1)'(1)));
  assign emit    = is_drn || (is_pix && (fcnt_q >= dlag)) || int_emit;
  assign out_last = ({1'b0, pr_q} == (h_eff - HEIGHT_W'(1)))
                 && ({1'b0, pc_q} == (w_eff - (CW+1)'(1)));

  always_comb begin
    vc_d   = vc_q;
    vr_d   = vr_q;
    pc_d   = pc_q;
    pr_d   = pr_q;
    fcnt_d = fcnt_q;
    done_d = done_q;
    pend_d = pend_q;
    if (feed) begin
      if ({1'b0, vc_q} == w_eff - (CW+1)'(1)) begin
        vc_d = '0;
        vr_d = vr_q + ROW_W'(1);
      end else begin
        vc_d = vc_q + CW'(1);
      end
      if (fcnt_q < dlag) fcnt_d = fcnt_q + DW'(1);
    end
    if (is_pix && last_in) done_d = 1'b1;
    if (is_pix && last_in && (fcnt_q < dlag)) pend_d = 1'b1;
    if (int_emit) pend_d = 1'b0;
    if (emit) begin
      if ({1'b0, pc_q} == w_eff - (CW+1)'(1)) begin
        pc_d = '0;
        pr_d = pr_q + ROW_W'(1);
      end else begin
        pc_d = pc_q + CW'(1);
      end
      if (out_last) begin
        pc_d   = '0;
        pr_d   = '0;
        vc_d   = '0;
        vr_d   = '0;
        fcnt_d = '0;
        done_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q   <= '0;
      vr_q   <= '0;
      pc_q   <= '0;
      pr_q   <= '0;
      fcnt_q <= '0;
      done_q <= 1'b0;
      pend_q <= 1'b0;
    end else begin
      vc_q   <= vc_d;
      vr_q   <= vr_d;
      pc_q   <= pc_d;
      pr_q   <= pr_d;
      fcnt_q <= fcnt_d;
      done_q <= done_d;
      pend_q <= pend_d;
    end
  end

  // window border masks for the position being emitted
  logic [MK-1:0] rowv, colv;

  always_comb begin
    int yy, xx;
    for (int i = 0; i < MK; i++) begin
      yy = int'(pr_q) + i - int'(step);
      xx = int'(pc_q) + i - int'(step);
      rowv[i] = (yy >= 0) && (yy < int'(h_eff));
      colv[i] = (xx >= 0) && (xx < int'(w_eff));
    end
  end

  // stage a: line-buffer read in flight
  logic              a_feed_q, a_emit_q, a_load_q, a_fwd_q, a_last_q;
  logic [PIX_W-1:0]  a_pix_q;
  logic [CW-1:0]     a_addr_q;
  logic [MK-1:0]     a_rowv_q, a_colv_q;
  logic [ROW_W-1:0]  a_row_q;
  logic [CW-1:0]     a_col_q;
  logic [CIW-1:0]    a_cidx_q;
  logic [COEF_W-1:0] a_cval_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_feed_q <= 1'b0;
      a_emit_q <= 1'b0;
      a_load_q <= 1'b0;
      a_fwd_q  <= 1'b0;
    end else begin
      a_feed_q <= feed;
      a_emit_q <= emit;
      a_load_q <= is_load;
      a_fwd_q  <= feed && a_feed_q && (a_addr_q == vc_q);
    end
  end

  always_ff @(posedge clk_i) begin
    a_pix_q  <= is_pix ? in_pix : '0;
    a_addr_q <= vc_q;
    a_rowv_q <= rowv;
    a_colv_q <= colv;
    a_row_q  <= pr_q;
    a_col_q  <= pc_q;
    a_last_q <= out_last;
    a_cidx_q <= CIW'(in_cidx);
    a_cval_q <= in_cval;
  end

  logic [PIX_W-1:0] lb_rdata [MK];
  logic [PIX_W-1:0] column [MK];
  logic [PIX_W-1:0] lastcol_q [MK];

  assign lb_rdata[MK-1] = '0;

  for (genvar m = 0; m < MK - 1; m++) begin : g_lbuf
    r2dcf_ram #(
      .WIDTH(PIX_W),
      .DEPTH(MAX_WIDTH)
    ) u_lbuf (
      .clk_i  (clk_i),
      .we_i   (a_feed_q),
      .waddr_i(a_addr_q),
      .wdata_i(column[m]),
      .re_i   (feed),
      .raddr_i(vc_q),
      .rdata_o(lb_rdata[m])
    );
  end

  always_comb begin
    column[0] = a_pix_q;
    for (int m = 1; m < MK; m++) begin
      column[m] = a_fwd_q ? lastcol_q[m-1] : lb_rdata[m-1];
    end
  end

  logic [PIX_W-1:0] win_q [MK][MK];

  always_ff @(posedge clk_i) begin
    if (a_feed_q) begin
      for (int m = 0; m < MK; m++) begin
        lastcol_q[m] <= column[m];
        for (int c = 0; c < MK - 1; c++) begin
          win_q[m][c] <= win_q[m][c+1];
        end
        win_q[m][MK-1] <= column[m];
      end
    end
  end

  // stage b: window ready, multiply
  logic              b_emit_q, b_load_q, b_last_q;
  logic [MK-1:0]     b_rowv_q, b_colv_q;
  logic [ROW_W-1:0]  b_row_q;
  logic [CW-1:0]     b_col_q;
  logic [CIW-1:0]    b_cidx_q;
  logic [COEF_W-1:0] b_cval_q;
  logic [COEF_W-1:0] coef_q [NCOEF];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_emit_q <= 1'b0;
      b_load_q <= 1'b0;
    end else begin
      b_emit_q <= a_emit_q;
      b_load_q <= a_load_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b_rowv_q <= a_rowv_q;
    b_colv_q <= a_colv_q;
    b_row_q  <= a_row_q;
    b_col_q  <= a_col_q;
    b_last_q <= a_last_q;
    b_cidx_q <= a_cidx_q;
    b_cval_q <= a_cval_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 0; n < NCOEF; n++) coef_q[n] <= '0;
    end else if (b_load_q) begin
      coef_q[b_cidx_q] <= b_cval_q;
    end
  end

  logic signed [PW-1:0] prod_d [MK][MK][3];
  logic signed [PW-1:0] prod_q [MK][MK][3];

  always_comb begin
    logic [PIX_W-1:0]  px;
    logic [COEF_W-1:0] cf;
    logic              act;
    int                ci;
    for (int i = 0; i < MK; i++) begin
      for (int j = 0; j < MK; j++) begin
        act = (i < int'(k_eff)) && (j < int'(k_eff)) && b_rowv_q[i] && b_colv_q[j];
        ci  = i + j * int'(k_eff);
        px  = '0;
        cf  = '0;
        if (act) begin
          px = win_q[int'(k_eff) - 1 - i][MK - int'(k_eff) + j];
          cf = coef_q[CIW'(ci)];
        end
        prod_d[i][j][0] = PW'($signed({1'b0, px[23:16]}) * $signed(cf));
        prod_d[i][j][1] = PW'($signed({1'b0, px[15:8]}) * $signed(cf));
        prod_d[i][j][2] = PW'($signed({1'b0, px[7:0]}) * $signed(cf));
      end
    end
  end

  // stage c: products, sum each column
  logic             c_emit_q, c_last_q;
  logic [ROW_W-1:0] c_row_q;
  logic [CW-1:0]    c_col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) c_emit_q <= 1'b0;
    else         c_emit_q <= b_emit_q;
  end

  always_ff @(posedge clk_i) begin
    prod_q   <= prod_d;
    c_row_q  <= b_row_q;
    c_col_q  <= b_col_q;
    c_last_q <= b_last_q;
  end

  logic signed [SW-1:0] csum_d [MK][3];
  logic signed [SW-1:0] csum_q [MK][3];

  always_comb begin
    for (int j = 0; j < MK; j++) begin
      for (int ch = 0; ch < 3; ch++) begin
        csum_d[j][ch] = '0;
        for (int i = 0; i < MK; i++) begin
          csum_d[j][ch] = csum_d[j][ch] + SW'(prod_q[i][j][ch]);
        end
      end
    end
  end

  // stage d: column sums, total and finish
  logic             d_emit_q, d_last_q;
  logic [ROW_W-1:0] d_row_q;
  logic [CW-1:0]    d_col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) d_emit_q <= 1'b0;
    else         d_emit_q <= c_emit_q;
  end

  always_ff @(posedge clk_i) begin
    csum_q   <= csum_d;
    d_row_q  <= c_row_q;
    d_col_q  <= c_col_q;
    d_last_q <= c_last_q;
  end

  logic [7:0] chan [3];

  always_comb begin
    logic signed [SW-1:0] tot;
    logic signed [SW-1:0] shf;
    for (int ch = 0; ch < 3; ch++) begin
      tot = '0;
      for (int j = 0; j < MK; j++) tot = tot + csum_q[j][ch];
      shf = tot >>> COEF_FRACTION_BITS;
      if (tot <= 0)                  chan[ch] = 8'd0;
      else if (shf > SW'(255))       chan[ch] = 8'd255;
      else                           chan[ch] = shf[7:0];
    end
  end

  // output queue
  beat_t              fifo_q [FIFO_DEPTH];
  beat_t              push_beat;
  logic [FIFO_PW-1:0] wptr_q, rptr_q;
  logic [FIFO_PW:0]   fcnt_out_q;
  logic               push, pop;
  logic [FIFO_PW+1:0] occ;

  assign push_beat = '{last: d_last_q, col: COL_W'(d_col_q), row: d_row_q,
                       blue: chan[2], green: chan[1], red: chan[0]};
  assign push = d_emit_q;
  assign pop  = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wptr_q] <= push_beat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q     <= '0;
      rptr_q     <= '0;
      fcnt_out_q <= '0;
    end else begin
      if (push) wptr_q <= wptr_q + FIFO_PW'(1);
      if (pop)  rptr_q <= rptr_q + FIFO_PW'(1);
      case ({push, pop})
        2'b10:   fcnt_out_q <= fcnt_out_q + (FIFO_PW+1)'(1);
        2'b01:   fcnt_out_q <= fcnt_out_q - (FIFO_PW+1)'(1);
        default: ;
      endcase
    end
  end

  assign occ = (FIFO_PW+2)'(fcnt_out_q) + (FIFO_PW+2)'(a_emit_q) + (FIFO_PW+2)'(b_emit_q)
             + (FIFO_PW+2)'(c_emit_q) + (FIFO_PW+2)'(d_emit_q);

  assign space         = occ < (FIFO_PW+2)'(FIFO_DEPTH);
  assign s_axis_tready = space && !pend_q;
  assign m_axis_tvalid = fcnt_out_q != '0;
  assign m_axis_tlast  = fifo_q[rptr_q].last;
  assign m_axis_tdata  = {2'b00, fifo_q[rptr_q].col, fifo_q[rptr_q].row,
                          fifo_q[rptr_q].blue, fifo_q[rptr_q].green,
                          fifo_q[rptr_q].red};

  a_fifo_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |-> fcnt_out_q < (FIFO_PW+1)'(FIFO_DEPTH))
    else $error("output queue overflow");

  a_occ_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ <= (FIFO_PW+2)'(FIFO_DEPTH))
    else $error("results in flight exceed queue space");

  a_early_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (cmd == CMD_DRAIN) && !done_q |=> !a_emit_q)
    else $error("drain before frame end produced a result");

  a_fwd_feed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_fwd_q |-> a_feed_q && $past(a_feed_q))
    else $error("forwarding without back-to-back columns");

endmodule

@@ hw/rtl/r2dcf_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r2dcf_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module r2dcf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
